// ===== rtl/ptve_pkg.sv =====
// ----------------------------------------------------------------------------
// ptve_pkg
// Shared codes, reset values and types of the pattern threshold video effect.
// ----------------------------------------------------------------------------
package ptve_pkg;

   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;

   // item kinds carried in req_tuser
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_PIXEL  = 2'd0;
   localparam logic [OP_W-1:0] OP_RIPPLE = 2'd1;
   localparam logic [OP_W-1:0] OP_SPIRAL = 2'd2;

   // configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_MASK = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_START_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_START_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_START_X = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_START_Y = 3'd6;

   localparam int SIZE_W  = 10;
   localparam int START_W = 9;
   localparam int MASK_W  = 24;
   localparam int TADDR_W = 20;
   localparam int PIX_W   = 32;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd512;
   localparam logic [MASK_W-1:0] MASK_RESET = 24'hffffff;

   // bit0 red x, bit1 red y, bit2 blue x, bit3 blue y; 1 = moving down
   localparam logic [3:0] DIRS_RESET = 4'b0011;
   localparam logic [7:0] PHASE_STEP = 8'd8;

   typedef struct packed {
      logic [7:0] phase;
      logic       last;
   } ptve_tag_type;

endpackage

// ===== rtl/ptve_pattern_mem.sv =====
// ----------------------------------------------------------------------------
// ptve_pattern_mem
// Ripple table (one write, two reads) and spiral table (one write, one read),
// read data registered.
// ----------------------------------------------------------------------------
module ptve_pattern_mem #(
   parameter int MAX_WIDTH  = ptve_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ptve_pkg::MAX_HEIGHT_DEF,
   localparam int RIP_DEPTH = 4 * MAX_WIDTH * MAX_HEIGHT,
   localparam int SPI_DEPTH = MAX_WIDTH * MAX_HEIGHT,
   localparam int RIP_AW    = $clog2(RIP_DEPTH),
   localparam int SPI_AW    = $clog2(SPI_DEPTH)
) (
   input  logic              clock,
   input  logic              rip_we,
   input  logic [RIP_AW-1:0] rip_waddr,
   input  logic              spi_we,
   input  logic [SPI_AW-1:0] spi_waddr,
   input  logic [7:0]        wdata,
   input  logic              rd_en,
   input  logic [RIP_AW-1:0] rip_raddr_a,
   input  logic [RIP_AW-1:0] rip_raddr_b,
   input  logic [SPI_AW-1:0] spi_raddr,
   output logic [7:0]        rip_rdata_a,
   output logic [7:0]        rip_rdata_b,
   output logic [7:0]        spi_rdata
);
   import ptve_pkg::*;

   logic [7:0] rip_mem [RIP_DEPTH];
   logic [7:0] spi_mem [SPI_DEPTH];
   logic [7:0] rip_a_ff, rip_b_ff, spi_ff;

   always_ff @(posedge clock) begin
      if (rip_we) begin
         rip_mem[rip_waddr] <= wdata;
      end
      if (rd_en) begin
         rip_a_ff <= rip_mem[rip_raddr_a];
         rip_b_ff <= rip_mem[rip_raddr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (spi_we) begin
         spi_mem[spi_waddr] <= wdata;
      end
      if (rd_en) begin
         spi_ff <= spi_mem[spi_raddr];
      end
   end

   assign rip_rdata_a = rip_a_ff;
   assign rip_rdata_b = rip_b_ff;
   assign spi_rdata   = spi_ff;

endmodule

// ===== rtl/ptve_raster_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptve_raster_ctrl
// Configuration registers, raster position, moving offsets and phase; forms
// the table read addresses of the next pixel.
// ----------------------------------------------------------------------------
module ptve_raster_ctrl #(
   parameter int MAX_WIDTH  = ptve_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ptve_pkg::MAX_HEIGHT_DEF,
   localparam int RIP_AW    = $clog2(4 * MAX_WIDTH * MAX_HEIGHT),
   localparam int SPI_AW    = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ptve_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ptve_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                pix_adv,
   output logic                                restart_busy,
   output logic [ptve_pkg::MASK_W-1:0]         channel_mask,
   output ptve_pkg::ptve_tag_type              tag,
   output logic [RIP_AW-1:0]                   rip_raddr_a,
   output logic [RIP_AW-1:0]                   rip_raddr_b,
   output logic [SPI_AW-1:0]                   spi_raddr
);
   import ptve_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int EWW = $clog2(MAX_WIDTH + 1);
   localparam int EHW = $clog2(MAX_HEIGHT + 1);
   localparam int BW  = ((EWW > EHW) ? EWW : EHW) + 1;
   localparam int RIP_STRIDE = 2 * MAX_WIDTH;

   logic [SIZE_W-1:0]  width_ff, height_ff;
   logic [MASK_W-1:0]  mask_ff;
   logic [START_W-1:0] rsx_ff, rsy_ff, bsx_ff, bsy_ff;
   logic               restart_ff, restart_in;

   logic [CW-1:0] col_ff, col_in, red_col_ff, red_col_in, blue_col_ff, blue_col_in;
   logic [RW-1:0] row_ff, row_in, red_row_ff, red_row_in, blue_row_ff, blue_row_in;
   logic [3:0]    dirs_ff, dirs_in;
   logic [7:0]    phase_ff, phase_in;

   logic [EWW-1:0] eff_w;
   logic [EHW-1:0] eff_h;
   logic [BW-1:0]  w_ext, h_ext, col_nx, row_nx;
   logic           col_end, row_end;
   logic [BW:0]    bn_rc, bn_rr, bn_bc, bn_br;
   logic [RW:0]    rsum_r, rsum_b;
   logic [CW:0]    csum_r, csum_b;

   function automatic logic [BW:0] bounce(input logic [BW-1:0] pos,
                                          input logic [BW-1:0] lim,
                                          input logic          neg);
      logic          hit;
      logic          n;
      logic [BW-1:0] p2;
      logic [BW-1:0] np;
      p2  = pos + BW'(2);
      hit = neg ? (pos < BW'(2)) : (p2 >= lim);
      n   = neg ^ hit;
      if (n) begin
         np = (pos >= BW'(2)) ? pos - BW'(2) : '0;
      end else begin
         np = (p2 < lim) ? p2 : lim - BW'(1);
      end
      return {n, np};
   endfunction

   always_comb begin
      eff_w = (width_ff < SIZE_W'(4)) ? EWW'(4) :
              ((32'(width_ff) > 32'(MAX_WIDTH)) ? EWW'(MAX_WIDTH) : EWW'(width_ff));
      eff_h = (height_ff < SIZE_W'(4)) ? EHW'(4) :
              ((32'(height_ff) > 32'(MAX_HEIGHT)) ? EHW'(MAX_HEIGHT) : EHW'(height_ff));
   end

   assign w_ext   = BW'(eff_w);
   assign h_ext   = BW'(eff_h);
   assign col_nx  = BW'(col_ff) + BW'(1);
   assign row_nx  = BW'(row_ff) + BW'(1);
   assign col_end = !(col_nx < w_ext);
   assign row_end = !(row_nx < h_ext);

   assign bn_rc = bounce(BW'(red_col_ff),  w_ext, dirs_ff[0]);
   assign bn_rr = bounce(BW'(red_row_ff),  h_ext, dirs_ff[1]);
   assign bn_bc = bounce(BW'(blue_col_ff), w_ext, dirs_ff[2]);
   assign bn_br = bounce(BW'(blue_row_ff), h_ext, dirs_ff[3]);

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      red_col_in  = red_col_ff;
      red_row_in  = red_row_ff;
      blue_col_in = blue_col_ff;
      blue_row_in = blue_row_ff;
      dirs_in     = dirs_ff;
      phase_in    = phase_ff;
      restart_in  = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH, CSR_FRAME_HEIGHT, CSR_RED_START_X, CSR_RED_START_Y,
            CSR_BLUE_START_X, CSR_BLUE_START_Y: restart_in = 1'b1;
            default: restart_in = 1'b0;
         endcase
      end
      if (restart_ff) begin
         red_col_in  = (32'(rsx_ff) < 32'(eff_w)) ? CW'(rsx_ff) : CW'(eff_w - EWW'(1));
         red_row_in  = (32'(rsy_ff) < 32'(eff_h)) ? RW'(rsy_ff) : RW'(eff_h - EHW'(1));
         blue_col_in = (32'(bsx_ff) < 32'(eff_w)) ? CW'(bsx_ff) : CW'(eff_w - EWW'(1));
         blue_row_in = (32'(bsy_ff) < 32'(eff_h)) ? RW'(bsy_ff) : RW'(eff_h - EHW'(1));
         dirs_in     = DIRS_RESET;
         phase_in    = '0;
         col_in      = '0;
         row_in      = '0;
      end else if (pix_adv) begin
         if (!col_end) begin
            col_in = CW'(col_nx);
         end else begin
            col_in = '0;
            if (!row_end) begin
               row_in = RW'(row_nx);
            end else begin
               row_in      = '0;
               phase_in    = phase_ff - PHASE_STEP;
               red_col_in  = CW'(bn_rc[BW-1:0]);
               red_row_in  = RW'(bn_rr[BW-1:0]);
               blue_col_in = CW'(bn_bc[BW-1:0]);
               blue_row_in = RW'(bn_br[BW-1:0]);
               dirs_in     = {bn_br[BW], bn_bc[BW], bn_rr[BW], bn_rc[BW]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= SIZE_RESET;
         height_ff   <= SIZE_RESET;
         mask_ff     <= MASK_RESET;
         rsx_ff      <= '0;
         rsy_ff      <= '0;
         bsx_ff      <= '0;
         bsy_ff      <= '0;
         restart_ff  <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
         red_col_ff  <= '0;
         red_row_ff  <= '0;
         blue_col_ff <= '0;
         blue_row_ff <= '0;
         dirs_ff     <= DIRS_RESET;
         phase_ff    <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[SIZE_W-1:0];
               CSR_FRAME_HEIGHT: height_ff <= csr_wdata[SIZE_W-1:0];
               CSR_CHANNEL_MASK: mask_ff   <= csr_wdata[MASK_W-1:0];
               CSR_RED_START_X:  rsx_ff    <= csr_wdata[START_W-1:0];
               CSR_RED_START_Y:  rsy_ff    <= csr_wdata[START_W-1:0];
               CSR_BLUE_START_X: bsx_ff    <= csr_wdata[START_W-1:0];
               CSR_BLUE_START_Y: bsy_ff    <= csr_wdata[START_W-1:0];
               default: ;
            endcase
         end
         restart_ff  <= restart_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         red_col_ff  <= red_col_in;
         red_row_ff  <= red_row_in;
         blue_col_ff <= blue_col_in;
         blue_row_ff <= blue_row_in;
         dirs_ff     <= dirs_in;
         phase_ff    <= phase_in;
      end
   end

   assign rsum_r = (RW+1)'(row_ff) + (RW+1)'(red_row_ff);
   assign rsum_b = (RW+1)'(row_ff) + (RW+1)'(blue_row_ff);
   assign csum_r = (CW+1)'(col_ff) + (CW+1)'(red_col_ff);
   assign csum_b = (CW+1)'(col_ff) + (CW+1)'(blue_col_ff);

   assign rip_raddr_a = RIP_AW'(rsum_r) * RIP_AW'(RIP_STRIDE) + RIP_AW'(csum_r);
   assign rip_raddr_b = RIP_AW'(rsum_b) * RIP_AW'(RIP_STRIDE) + RIP_AW'(csum_b);
   assign spi_raddr   = SPI_AW'(row_ff) * SPI_AW'(MAX_WIDTH) + SPI_AW'(col_ff);

   assign tag.phase    = phase_ff;
   assign tag.last     = col_end && row_end;
   assign channel_mask = mask_ff;
   assign restart_busy = restart_ff;

endmodule

// ===== rtl/ptve_pixel_stage.sv =====
// ----------------------------------------------------------------------------
// ptve_pixel_stage
// Lookup stage and output register: thresholds the pixel, gates channels with
// the pattern bytes, applies the channel mask.
// ----------------------------------------------------------------------------
module ptve_pixel_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [ptve_pkg::PIX_W-1:0]    in_pixel,
   input  ptve_pkg::ptve_tag_type        in_tag,
   input  logic [7:0]                    rip_r,
   input  logic [7:0]                    rip_b,
   input  logic [7:0]                    spi,
   input  logic [ptve_pkg::MASK_W-1:0]   channel_mask,
   output logic                          stage_ready,
   output logic                          out_valid,
   output logic [ptve_pkg::PIX_W-1:0]    out_pixel,
   output logic                          out_last,
   input  logic                          out_ready
);
   import ptve_pkg::*;

   logic               s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]   s1_pixel_ff;
   ptve_tag_type       s1_tag_ff;
   logic               out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]   out_pixel_ff;
   logic               out_last_ff;
   logic               advance;
   logic [7:0]         ph2, gr, gg, gb;
   logic [PIX_W-1:0]   result;

   assign advance     = s1_valid_ff && (!out_valid_ff || out_ready);
   assign stage_ready = !s1_valid_ff || advance;

   assign ph2 = {s1_tag_ff.phase[6:0], 1'b0};
   assign gr  = rip_r + ph2;
   assign gg  = spi + ph2 + s1_tag_ff.phase;
   assign gb  = rip_b - s1_tag_ff.phase;

   assign result = {s1_pixel_ff[31:24],
                    {8{s1_pixel_ff[23] & gr[7]}} & channel_mask[23:16],
                    {8{s1_pixel_ff[15] & gg[7]}} & channel_mask[15:8],
                    {8{s1_pixel_ff[7]  & gb[7]}} & channel_mask[7:0]};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (stage_ready) begin
         s1_valid_in = in_valid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && stage_ready) begin
         s1_pixel_ff <= in_pixel;
         s1_tag_ff   <= in_tag;
      end
      if (advance) begin
         out_pixel_ff <= result;
         out_last_ff  <= s1_tag_ff.last;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pixel = out_pixel_ff;
   assign out_last  = out_last_ff;

endmodule

// ===== rtl/pattern_threshold_video_effect_unit.sv =====
// ----------------------------------------------------------------------------
// pattern_threshold_video_effect_unit
// Thresholds ARGB pixels and gates each color by moving ripple and spiral
// pattern tables held in on-chip memories; also loads those tables.
//
// Channel  Ports                       Direction  Contents
// req      req_tvalid/tready/tdata/tuser  in      pixel or table-load item
// rsp      rsp_tvalid/tready/tdata/tlast  out     effected pixel, frame end
// csr      csr_we/index/wdata             in      register write
//
// One transaction per clock sustained while rsp is ready and no reload is pending;
// tables read at the accepting edge, then the pixel goes to the output register.
// Reset is synchronous; tables are not cleared and need loading before use.
// A write of a geometry or start register holds req_tready low one cycle
// while the offsets reload. rsp stalls back up through two pixel slots.
// ----------------------------------------------------------------------------
module pattern_threshold_video_effect_unit #(
   parameter int MAX_WIDTH  = ptve_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ptve_pkg::MAX_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [63:0]                     req_tdata,  // pixel, table_addr, table_value
   input  logic [ptve_pkg::OP_W-1:0]       req_tuser,  // op
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,  // pixel_out
   output logic                            rsp_tlast,  // last_of_frame
   input  logic                            csr_we,
   input  logic [ptve_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ptve_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ptve_pkg::*;

   localparam int RIP_DEPTH = 4 * MAX_WIDTH * MAX_HEIGHT;
   localparam int SPI_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int RIP_AW    = $clog2(RIP_DEPTH);
   localparam int SPI_AW    = $clog2(SPI_DEPTH);

   logic               accept, pix_acc, stage_ready, restart_busy;
   logic [PIX_W-1:0]   in_pixel;
   logic [TADDR_W-1:0] in_taddr;
   logic [7:0]         in_tval;
   logic               rip_we, spi_we;
   logic [RIP_AW-1:0]  rip_raddr_a, rip_raddr_b;
   logic [SPI_AW-1:0]  spi_raddr;
   logic [7:0]         rip_rdata_a, rip_rdata_b, spi_rdata;
   logic [MASK_W-1:0]  channel_mask;
   ptve_tag_type       tag;

   assign in_pixel = req_tdata[31:0];
   assign in_taddr = req_tdata[51:32];
   assign in_tval  = req_tdata[59:52];

   assign req_tready = stage_ready && !restart_busy;
   assign accept     = req_tvalid && req_tready;
   assign pix_acc    = accept && (req_tuser == OP_PIXEL);
   assign rip_we     = accept && (req_tuser == OP_RIPPLE) &&
                       (32'(in_taddr) < 32'(RIP_DEPTH));
   assign spi_we     = accept && (req_tuser == OP_SPIRAL) &&
                       (32'(in_taddr) < 32'(SPI_DEPTH));

   ptve_raster_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .pix_adv      (pix_acc),
      .restart_busy (restart_busy),
      .channel_mask (channel_mask),
      .tag          (tag),
      .rip_raddr_a  (rip_raddr_a),
      .rip_raddr_b  (rip_raddr_b),
      .spi_raddr    (spi_raddr)
   );

   ptve_pattern_mem #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_mem (
      .clock       (clock),
      .rip_we      (rip_we),
      .rip_waddr   (RIP_AW'(32'(in_taddr))),
      .spi_we      (spi_we),
      .spi_waddr   (SPI_AW'(32'(in_taddr))),
      .wdata       (in_tval),
      .rd_en       (pix_acc),
      .rip_raddr_a (rip_raddr_a),
      .rip_raddr_b (rip_raddr_b),
      .spi_raddr   (spi_raddr),
      .rip_rdata_a (rip_rdata_a),
      .rip_rdata_b (rip_rdata_b),
      .spi_rdata   (spi_rdata)
   );

   ptve_pixel_stage u_pix (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (pix_acc),
      .in_pixel     (in_pixel),
      .in_tag       (tag),
      .rip_r        (rip_rdata_a),
      .rip_b        (rip_rdata_b),
      .spi          (spi_rdata),
      .channel_mask (channel_mask),
      .stage_ready  (stage_ready),
      .out_valid    (rsp_tvalid),
      .out_pixel    (rsp_tdata),
      .out_last     (rsp_tlast),
      .out_ready    (rsp_tready)
   );

endmodule

// ===== test/pattern_threshold_video_effect_unit_tb.sv =====
// ----------------------------------------------------------------------------
// pattern_threshold_video_effect_unit_tb
// Self-checking bench for the pattern threshold video effect. Pixels and
// table loads go in on req, effected pixels come back on rsp and are compared
// field by field against an in-bench predictor that tracks the pattern
// tables, frame raster, phase and bouncing ripple offsets. Table entries are
// loaded before any pixel reads them. Tests cover field extremes, every
// operation, geometry and start clamping, phase wraparound, an oversized
// width, output stalls long enough to back up the input, and random
// streams with random idling on both sides.
// ----------------------------------------------------------------------------
module pattern_threshold_video_effect_unit_tb;
   import ptve_pkg::*;

   localparam int FRAME_MAX       = MAX_WIDTH_DEF;
   localparam int LINE_MAX        = MAX_HEIGHT_DEF;
   localparam int RIPPLE_STRIDE   = 2 * FRAME_MAX;
   localparam int RIPPLE_DEPTH    = 4 * FRAME_MAX * LINE_MAX;
   localparam int SPIRAL_STRIDE   = FRAME_MAX;
   localparam int SPIRAL_DEPTH    = FRAME_MAX * LINE_MAX;
   localparam int DRAIN_CYCLES    = 4;
   localparam int LONG_HOLD       = 64;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_ITEMS    = 220;
   localparam int CALM_ITEMS      = 70;
   localparam int DIR_RED_X       = 0;
   localparam int DIR_RED_Y       = 1;
   localparam int DIR_BLUE_X      = 2;
   localparam int DIR_BLUE_Y      = 3;
   localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [31:0] pixel_out;
      logic        last_of_frame;
   } effect_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [63:0]           req_tdata  = '0;  // pixel, table_addr, table_value
   logic [OP_W-1:0]       req_tuser  = OP_PIXEL;  // op
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;  // pixel_out
   logic                  rsp_tlast;  // last_of_frame
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // predictor state
   logic [7:0]        ripple_shadow [int];
   logic [7:0]        spiral_shadow [int];
   logic [SIZE_W-1:0] cfg_width, cfg_height;
   logic [MASK_W-1:0] cfg_mask;
   logic [8:0]        cfg_red_x, cfg_red_y, cfg_blue_x, cfg_blue_y;
   logic [8:0]        red_x, red_y, blue_x, blue_y;
   logic [3:0]        motion_dirs;
   logic [7:0]        fx_phase;
   logic [8:0]        raster_col, raster_row;

   effect_result_type expected_pixels [$];
   int             fail_count   = 0;
   int             items_sent   = 0;
   int             quiet_cycles = 0;
   logic           idle_on      = 1'b1;
   logic           hold_request = 1'b0;

   pattern_threshold_video_effect_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic int clamped_width();
      int w;
      w = int'(cfg_width);
      if (w < 4) w = 4;
      if (w > FRAME_MAX) w = FRAME_MAX;
      return w;
   endfunction

   function automatic int clamped_height();
      int h;
      h = int'(cfg_height);
      if (h < 4) h = 4;
      if (h > LINE_MAX) h = LINE_MAX;
      return h;
   endfunction

   function automatic void restart_motion();
      int w, h;
      w = clamped_width();
      h = clamped_height();
      red_x       = (int'(cfg_red_x) < w) ? cfg_red_x : 9'(w - 1);
      red_y       = (int'(cfg_red_y) < h) ? cfg_red_y : 9'(h - 1);
      blue_x      = (int'(cfg_blue_x) < w) ? cfg_blue_x : 9'(w - 1);
      blue_y      = (int'(cfg_blue_y) < h) ? cfg_blue_y : 9'(h - 1);
      motion_dirs = DIRS_RESET;
      fx_phase    = '0;
      raster_col  = '0;
      raster_row  = '0;
   endfunction

   function automatic void reset_effect_state();
      ripple_shadow.delete();
      spiral_shadow.delete();
      cfg_width  = SIZE_RESET;
      cfg_height = SIZE_RESET;
      cfg_mask   = MASK_RESET;
      cfg_red_x  = '0;
      cfg_red_y  = '0;
      cfg_blue_x = '0;
      cfg_blue_y = '0;
      restart_motion();
   endfunction

   // step an offset by 2, turning around at the frame edges
   function automatic logic [8:0] bounce_offset(input int pos, input int lim, input int dir_bit);
      logic down;
      down = motion_dirs[dir_bit];
      if (down ? (pos < 2) : (pos + 2 >= lim)) begin
         down = ~down;
         motion_dirs[dir_bit] = down;
      end
      if (down) return (pos >= 2) ? 9'(pos - 2) : 9'd0;
      return (pos + 2 < lim) ? 9'(pos + 2) : 9'(lim - 1);
   endfunction

   function automatic void locate_taps(output int red_addr, output int spiral_addr,
                                       output int blue_addr);
      if (int'(raster_col) >= clamped_width()) raster_col = '0;
      if (int'(raster_row) >= clamped_height()) raster_row = '0;
      red_addr    = ((int'(raster_row) + int'(red_y)) * RIPPLE_STRIDE
                     + int'(raster_col) + int'(red_x)) % RIPPLE_DEPTH;
      spiral_addr = (int'(raster_row) * SPIRAL_STRIDE + int'(raster_col)) % SPIRAL_DEPTH;
      blue_addr   = ((int'(raster_row) + int'(blue_y)) * RIPPLE_STRIDE
                     + int'(raster_col) + int'(blue_x)) % RIPPLE_DEPTH;
   endfunction

   function automatic effect_result_type apply_effect(input logic [31:0] px);
      int                ra, sa, ba, w, h;
      logic [7:0]        red_gate, green_gate, blue_gate;
      logic [23:0]       rgb;
      effect_result_type r;
      locate_taps(ra, sa, ba);
      w = clamped_width();
      h = clamped_height();
      red_gate   = ripple_shadow[ra] + 8'(2 * fx_phase);
      green_gate = spiral_shadow[sa] + 8'(3 * fx_phase);
      blue_gate  = ripple_shadow[ba] - fx_phase;
      rgb = {(px[23] && red_gate[7])   ? 8'hff : 8'h00,
             (px[15] && green_gate[7]) ? 8'hff : 8'h00,
             (px[7]  && blue_gate[7])  ? 8'hff : 8'h00};
      r.pixel_out     = {px[31:24], rgb & cfg_mask};
      r.last_of_frame = (int'(raster_col) == w - 1) && (int'(raster_row) == h - 1);
      if (int'(raster_col) + 1 < w) begin
         raster_col = raster_col + 1'b1;
      end else begin
         raster_col = '0;
         if (int'(raster_row) + 1 < h) begin
            raster_row = raster_row + 1'b1;
         end else begin
            raster_row = '0;
            fx_phase   = fx_phase - PHASE_STEP;
            red_x      = bounce_offset(red_x, w, DIR_RED_X);
            red_y      = bounce_offset(red_y, h, DIR_RED_Y);
            blue_x     = bounce_offset(blue_x, w, DIR_BLUE_X);
            blue_y     = bounce_offset(blue_y, h, DIR_BLUE_Y);
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic send_item(input logic [OP_W-1:0] op, input logic [31:0] px,
                            input logic [TADDR_W-1:0] addr, input logic [7:0] val);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, val, addr, px};
      case (op)
         OP_PIXEL:  expected_pixels.push_back(apply_effect(px));
         OP_RIPPLE: ripple_shadow[int'(addr)] = val;
         OP_SPIRAL: if (int'(addr) < SPIRAL_DEPTH) spiral_shadow[int'(addr)] = val;
         default: ;
      endcase
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_PIXEL || op == OP_RIPPLE || (op == OP_SPIRAL && int'(addr) < SPIRAL_DEPTH))
         items_sent++;
      @(negedge clock);
   endtask

   // loads any table entry the next pixel reads that is still unwritten
   task automatic send_pixel(input logic [31:0] px);
      int ra, sa, ba;
      locate_taps(ra, sa, ba);
      if (!ripple_shadow.exists(ra))
         send_item(OP_RIPPLE, $urandom, TADDR_W'(ra), 8'($urandom));
      if (!spiral_shadow.exists(sa))
         send_item(OP_SPIRAL, $urandom, TADDR_W'(sa), 8'($urandom));
      if (!ripple_shadow.exists(ba))
         send_item(OP_RIPPLE, $urandom, TADDR_W'(ba), 8'($urandom));
      send_item(OP_PIXEL, px, TADDR_W'($urandom), 8'($urandom));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_FRAME_WIDTH:  cfg_width  = value[SIZE_W-1:0];
         CSR_FRAME_HEIGHT: cfg_height = value[SIZE_W-1:0];
         CSR_CHANNEL_MASK: cfg_mask   = value[MASK_W-1:0];
         CSR_RED_START_X:  cfg_red_x  = value[START_W-1:0];
         CSR_RED_START_Y:  cfg_red_y  = value[START_W-1:0];
         CSR_BLUE_START_X: cfg_blue_x = value[START_W-1:0];
         CSR_BLUE_START_Y: cfg_blue_y = value[START_W-1:0];
         default: ;
      endcase
      if (idx != CSR_CHANNEL_MASK && idx != CSR_UNUSED) restart_motion();
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure_frame(input logic [23:0] width, input logic [23:0] height,
                                  input logic [23:0] mask, input logic [23:0] rx,
                                  input logic [23:0] ry, input logic [23:0] bx,
                                  input logic [23:0] by);
      wait_idle();
      write_register(CSR_FRAME_WIDTH, width);
      write_register(CSR_FRAME_HEIGHT, height);
      write_register(CSR_CHANNEL_MASK, mask);
      write_register(CSR_RED_START_X, rx);
      write_register(CSR_RED_START_Y, ry);
      write_register(CSR_BLUE_START_X, bx);
      write_register(CSR_BLUE_START_Y, by);
   endtask

   function automatic logic coin();
      return $urandom_range(0, 1) == 1;
   endfunction

   function automatic logic [23:0] size_value();
      int         pick;
      logic [9:0] s;
      pick = $urandom_range(0, 19);
      if (pick < 15)      s = 10'($urandom_range(4, 9));
      else if (pick < 17) s = 10'($urandom_range(0, 3));
      else if (pick < 19) s = 10'($urandom_range(10, 24));
      else                s = 10'($urandom_range(FRAME_MAX, 1023));
      return {14'($urandom), s};
   endfunction

   function automatic logic [23:0] start_value();
      logic [8:0] s;
      s = ($urandom_range(0, 4) < 3) ? 9'($urandom_range(0, 9)) : 9'($urandom);
      return {15'($urandom), s};
   endfunction

   function automatic logic [23:0] mask_value();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 24'h000000;
      if (pick < 4) return MASK_RESET;
      return 24'($urandom);
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_directed_items();
      send_item(OP_SPIRAL, 32'h0, 20'hfffff, 8'h55);
      send_item(OP_SPIRAL, 32'h0, 20'h3ffff, 8'haa);
      send_item(OP_RIPPLE, 32'h0, 20'hfffff, 8'hff);
      send_item(OP_RIPPLE, 32'hffffffff, 20'h00000, 8'h80);
      send_item(OP_SPIRAL, 32'hffffffff, 20'h00000, 8'h7f);
      send_item(OP_UNUSED, 32'hffffffff, 20'hfffff, 8'hff);
      send_pixel(32'hffffffff);
      send_item(OP_RIPPLE, 32'h0, 20'h00001, 8'h7f);
      send_item(OP_SPIRAL, 32'h0, 20'h00001, 8'h80);
      send_pixel(32'hffffffff);
      send_pixel(32'h00000000);
      send_pixel(32'h80808080);
      send_pixel(32'h7f7f7f7f);
      send_pixel(32'h00ff00ff);
      wait_idle();
      write_register(CSR_UNUSED, 24'hffffff);
      write_register(CSR_CHANNEL_MASK, 24'h000000);
      send_pixel(32'hffffffff);
      wait_idle();
      write_register(CSR_CHANNEL_MASK, MASK_RESET);
      send_pixel(32'hff7fff80);
   endtask

   // 4x4 frames: the phase wraps below zero and the offsets bounce;
   // starts clamp to the frame
   task automatic test_phase_wrap();
      configure_frame(24'd4, 24'd4, MASK_RESET, 24'd511, 24'd200, 24'd1, 24'd2);
      repeat (5 * 16) send_pixel($urandom);
   endtask

   task automatic test_wide_line();
      configure_frame(24'd1023, 24'd2, MASK_RESET, 24'd511, 24'd0, 24'd511, 24'd0);
      repeat (40) send_pixel($urandom);
   endtask

   task automatic test_tall_frame();
      configure_frame(24'd0, 24'd600, mask_value(), 24'd0, 24'd511, 24'd3, 24'd509);
      repeat (24) send_pixel($urandom);
   endtask

   task automatic test_receiver_hold();
      configure_frame(24'd6, 24'd5, 24'($urandom), 24'd2, 24'd1, 24'd4, 24'd3);
      hold_request = 1'b1;
      repeat (20) send_pixel($urandom);
   endtask

   task automatic test_random_stream();
      int   target, count, roll;
      logic all;
      target = items_sent + RANDOM_ITEMS;
      all    = 1'b1;
      while (items_sent < target) begin
         wait_idle();
         if (items_sent >= target - CALM_ITEMS) idle_on = 1'b0;
         else idle_on = ($urandom_range(0, 3) != 0);
         if (all || coin()) write_register(CSR_FRAME_WIDTH, size_value());
         if (all || coin()) write_register(CSR_FRAME_HEIGHT, size_value());
         if (all || coin()) write_register(CSR_CHANNEL_MASK, mask_value());
         if (all || coin()) write_register(CSR_RED_START_X, start_value());
         if (all || coin()) write_register(CSR_RED_START_Y, start_value());
         if (all || coin()) write_register(CSR_BLUE_START_X, start_value());
         if (all || coin()) write_register(CSR_BLUE_START_Y, start_value());
         all   = 1'b0;
         count = $urandom_range(24, 120);
         while (count > 0 && items_sent < target) begin
            count--;
            if (items_sent >= target - CALM_ITEMS) idle_on = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 84)
               send_pixel($urandom);
            else if (roll < 90)
               send_item(OP_RIPPLE, $urandom, TADDR_W'($urandom), 8'($urandom));
            else if (roll < 95)
               send_item(OP_SPIRAL, $urandom, TADDR_W'($urandom), 8'($urandom));
            else
               send_item(OP_UNUSED, $urandom, TADDR_W'($urandom), 8'($urandom));
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      effect_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected rsp transaction: pixel_out %h last_of_frame %b",
                   rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata !== want.pixel_out) begin
               $error("pixel_out: expected %h, actual %h", want.pixel_out, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want.last_of_frame) begin
               $error("last_of_frame: expected %b, actual %b", want.last_of_frame, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      reset_effect_state();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_items();
      test_phase_wrap();
      test_wide_line();
      test_tall_frame();
      test_receiver_hold();
      test_random_stream();
      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
